/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, switched off during reset.
`define SCLE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock, also checked during reset.
`define SCLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/scle_pkg.sv */
// Types and constants shared by the length and envelope controller and its checker.
package scle_pkg;

    localparam int CH_SEL_W       = 2;
    localparam int REG_SEL_W      = 2;
    localparam int DATA_W         = 8;
    localparam int TIMER_W        = 16;
    localparam int VOL_W          = 4;
    localparam int DUTY_W         = 2;
    localparam int OUT_CHANNELS   = 3;
    localparam int LEN_W          = 6;
    localparam int LEN_TICK_BITS  = 14;
    localparam int ENV_PERIOD_W   = 3;

    localparam logic [LEN_W-1:0] LEN_RELOAD = 6'b111111;
    localparam logic [VOL_W-1:0] VOL_MAX    = 4'b1111;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_LEN_DUTY = 2'd0,
        REG_ENVELOPE = 2'd1,
        REG_CONTROL  = 2'd2
    } t_reg_sel;

endpackage

/* hw/rtl/sound_channel_length_envelope_ctrl.sv */
// Length counter and volume envelope controller for the enveloped sound channels.
//
// The input channel (i_in_valid / o_in_ready) carries one item per register
// write or timer tick, selected by i_command. A write stores a byte into the
// length/duty or envelope register of one channel, or bits 7 and 6 (trigger,
// length enable) into its control register. A tick runs, for every channel
// in parallel, the pending trigger, the length counter and the envelope step.
// Every accepted item yields exactly one result item on the output channel
// (o_out_valid / i_out_ready) holding the volumes, active mask and duties
// after that item. The result is registered at the edge that accepts the
// item. One item is taken per cycle for as long as the result register is
// empty or is being emptied in the same cycle. When the receiver stalls, the
// result stays registered and o_in_ready falls until it is taken. A synchronous
// reset clears all channel state to zero and empties the result register.
module sound_channel_length_envelope_ctrl
    import scle_pkg::*;
#(
    parameter int CHANNELS = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [CH_SEL_W-1:0]  i_channel_sel,
    input  logic [REG_SEL_W-1:0] i_reg_sel,
    input  logic [DATA_W-1:0]    i_write_data,
    input  logic [TIMER_W-1:0]   i_timer,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [VOL_W-1:0]     o_volume_pulse_one,
    output logic [VOL_W-1:0]     o_volume_pulse_two,
    output logic [VOL_W-1:0]     o_volume_noise,
    output logic [OUT_CHANNELS-1:0] o_active_mask,
    output logic [DUTY_W-1:0]    o_duty_pulse_one,
    output logic [DUTY_W-1:0]    o_duty_pulse_two
);

    logic             w_accept;
    logic             w_is_tick;
    logic             w_len_tick;
    logic             w_env_tick;
    logic [VOL_W-1:0] n_vol_all  [CHANNELS];
    logic             n_act_all  [CHANNELS];
    logic [DUTY_W-1:0] n_duty_all [CHANNELS];

    logic [VOL_W-1:0]  w_vol_out  [OUT_CHANNELS];
    logic [DUTY_W-1:0] w_duty_out [OUT_CHANNELS];
    logic [OUT_CHANNELS-1:0] w_mask_out;

    logic                    r_out_valid;
    logic [VOL_W-1:0]        r_vol_p1;
    logic [VOL_W-1:0]        r_vol_p2;
    logic [VOL_W-1:0]        r_vol_noise;
    logic [OUT_CHANNELS-1:0] r_mask;
    logic [DUTY_W-1:0]       r_duty_p1;
    logic [DUTY_W-1:0]       r_duty_p2;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_tick  = (i_command == CMD_TICK);
    assign w_len_tick = (i_timer[LEN_TICK_BITS-1:0] == '0);
    assign w_env_tick = (i_timer == '0);

    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        localparam bit WRITABLE = (c < OUT_CHANNELS);

        logic [DATA_W-1:0] r_len_duty, n_len_duty;
        logic [DATA_W-1:0] r_env, n_env;
        logic              r_trig, n_trig;
        logic              r_len_en, n_len_en;
        logic [VOL_W-1:0]  r_vol, n_vol;
        logic              r_act, n_act;
        logic              w_sel;

        assign w_sel = WRITABLE && (i_channel_sel == CH_SEL_W'(c));

        always_comb begin
            n_len_duty = r_len_duty;
            n_env      = r_env;
            n_trig     = r_trig;
            n_len_en   = r_len_en;
            n_vol      = r_vol;
            n_act      = r_act;
            if (!w_is_tick) begin
                if (w_sel) begin
                    case (i_reg_sel)
                        REG_LEN_DUTY: n_len_duty = i_write_data;
                        REG_ENVELOPE: n_env = i_write_data;
                        REG_CONTROL: begin
                            n_trig   = i_write_data[7];
                            n_len_en = i_write_data[6];
                        end
                        default: ;
                    endcase
                end
            end else begin
                if (r_trig) begin
                    n_act  = 1'b1;
                    n_trig = 1'b0;
                    n_vol  = r_env[DATA_W-1 -: VOL_W];
                    if (r_len_duty[LEN_W-1:0] == '0) begin
                        n_len_duty[LEN_W-1:0] = LEN_RELOAD;
                    end
                end
                if (r_len_en && w_len_tick) begin
                    if (n_len_duty[LEN_W-1:0] != '0) begin
                        n_len_duty[LEN_W-1:0] = n_len_duty[LEN_W-1:0] - LEN_W'(1);
                    end else begin
                        n_vol = '0;
                        n_act = 1'b0;
                    end
                end
                if (w_env_tick && (r_env[ENV_PERIOD_W-1:0] != '0)) begin
                    if (r_env[ENV_PERIOD_W]) begin
                        if (n_vol != VOL_MAX) begin
                            n_vol = n_vol + VOL_W'(1);
                        end
                    end else begin
                        if (n_vol != '0) begin
                            n_vol = n_vol - VOL_W'(1);
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_len_duty <= '0;
                r_env      <= '0;
                r_trig     <= 1'b0;
                r_len_en   <= 1'b0;
                r_vol      <= '0;
                r_act      <= 1'b0;
            end else if (w_accept) begin
                r_len_duty <= n_len_duty;
                r_env      <= n_env;
                r_trig     <= n_trig;
                r_len_en   <= n_len_en;
                r_vol      <= n_vol;
                r_act      <= n_act;
            end
        end

        assign n_vol_all[c]  = n_vol;
        assign n_act_all[c]  = n_act;
        assign n_duty_all[c] = n_len_duty[DATA_W-1 -: DUTY_W];
    end

    for (genvar k = 0; k < OUT_CHANNELS; k++) begin : g_out
        if (k < CHANNELS) begin : g_present
            assign w_vol_out[k]  = n_vol_all[k];
            assign w_duty_out[k] = n_duty_all[k];
            assign w_mask_out[k] = n_act_all[k];
        end else begin : g_absent
            assign w_vol_out[k]  = '0;
            assign w_duty_out[k] = '0;
            assign w_mask_out[k] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_vol_p1    <= '0;
            r_vol_p2    <= '0;
            r_vol_noise <= '0;
            r_mask      <= '0;
            r_duty_p1   <= '0;
            r_duty_p2   <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_vol_p1    <= w_vol_out[0];
                r_vol_p2    <= w_vol_out[1];
                r_vol_noise <= w_vol_out[2];
                r_mask      <= w_mask_out;
                r_duty_p1   <= w_duty_out[0];
                r_duty_p2   <= w_duty_out[1];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_volume_pulse_one = r_vol_p1;
    assign o_volume_pulse_two = r_vol_p2;
    assign o_volume_noise     = r_vol_noise;
    assign o_active_mask      = r_mask;
    assign o_duty_pulse_one   = r_duty_p1;
    assign o_duty_pulse_two   = r_duty_p2;

endmodule

/* hw/rtl/scle_checker.sv */
// Port-level checker for the length and envelope controller, bound to the top level.
`include "assert_macros.svh"

module scle_checker
    import scle_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    i_command,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [VOL_W-1:0]        o_volume_pulse_one,
    input logic [VOL_W-1:0]        o_volume_pulse_two,
    input logic [VOL_W-1:0]        o_volume_noise,
    input logic [OUT_CHANNELS-1:0] o_active_mask,
    input logic [DUTY_W-1:0]       o_duty_pulse_one,
    input logic [DUTY_W-1:0]       o_duty_pulse_two
);

    logic w_in_acc;
    logic w_stall;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_stall  = o_out_valid && !i_out_ready;

    property p_reset_empty;
        !i_rst_n |=> !o_out_valid;
    endproperty

    property p_item_result;
        w_in_acc |=> o_out_valid;
    endproperty

    property p_write_levels;
        (w_in_acc && (i_command == CMD_WRITE)) |=>
            ($stable(o_volume_pulse_one) && $stable(o_volume_pulse_two) &&
             $stable(o_volume_noise) && $stable(o_active_mask));
    endproperty

    property p_stall_hold;
        w_stall |=> (o_out_valid && $stable(o_duty_pulse_one) &&
                     $stable(o_duty_pulse_two) && $stable(o_active_mask));
    endproperty

    `SCLE_ASSERT_ALWAYS(a_reset_empties, i_clk, p_reset_empty, "result left after reset")

    `SCLE_ASSERT_RST(a_item_gives_result, i_clk, i_rst_n, p_item_result, "item gave no result")

    `SCLE_ASSERT_RST(a_write_keeps_levels, i_clk, i_rst_n, p_write_levels, "write changed a level")

    `SCLE_ASSERT_RST(a_stall_holds, i_clk, i_rst_n, p_stall_hold, "stalled result changed")

endmodule

bind sound_channel_length_envelope_ctrl scle_checker u_scle_checker (.*);

/* test/tb_sound_channel_length_envelope_ctrl.sv */
// Self-checking testbench for the sound channel length and envelope controller.
module tb_sound_channel_length_envelope_ctrl;
    import scle_pkg::*;

    localparam logic [CH_SEL_W-1:0]  CH_PULSE_ONE = 2'd0;
    localparam logic [CH_SEL_W-1:0]  CH_PULSE_TWO = 2'd1;
    localparam logic [CH_SEL_W-1:0]  CH_NOISE     = 2'd2;
    localparam logic [CH_SEL_W-1:0]  CH_UNUSED    = 2'd3;
    localparam logic [REG_SEL_W-1:0] REG_UNUSED   = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_OFF_SPAN = 60;

    typedef struct packed {
        logic [VOL_W-1:0]        vol_one;
        logic [VOL_W-1:0]        vol_two;
        logic [VOL_W-1:0]        vol_noise;
        logic [OUT_CHANNELS-1:0] active;
        logic [DUTY_W-1:0]       duty_one;
        logic [DUTY_W-1:0]       duty_two;
    } t_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_command;
    logic [CH_SEL_W-1:0]  i_channel_sel;
    logic [REG_SEL_W-1:0] i_reg_sel;
    logic [DATA_W-1:0]    i_write_data;
    logic [TIMER_W-1:0]   i_timer;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [VOL_W-1:0]     o_volume_pulse_one;
    logic [VOL_W-1:0]     o_volume_pulse_two;
    logic [VOL_W-1:0]     o_volume_noise;
    logic [OUT_CHANNELS-1:0] o_active_mask;
    logic [DUTY_W-1:0]    o_duty_pulse_one;
    logic [DUTY_W-1:0]    o_duty_pulse_two;

    logic [DATA_W-1:0] ch_len_duty [OUT_CHANNELS];
    logic [DATA_W-1:0] ch_envelope [OUT_CHANNELS];
    logic [1:0]        ch_control  [OUT_CHANNELS];
    logic [VOL_W-1:0]  ch_volume   [OUT_CHANNELS];
    logic              ch_active   [OUT_CHANNELS];

    t_status     status_expected_q[$];
    int unsigned write_count = 0;
    int unsigned ignored_writes = 0;
    int unsigned tick_count = 0;
    int unsigned checked_count = 0;
    int unsigned error_count = 0;
    int unsigned stall_count = 0;
    bit          sender_quiet = 1'b0;
    bit          receiver_quiet = 1'b0;
    bit          hold_off_req = 1'b0;
    int          hold_left = 0;

    sound_channel_length_envelope_ctrl dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_channel_sel      (i_channel_sel),
        .i_reg_sel          (i_reg_sel),
        .i_write_data       (i_write_data),
        .i_timer            (i_timer),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_volume_pulse_one (o_volume_pulse_one),
        .o_volume_pulse_two (o_volume_pulse_two),
        .o_volume_noise     (o_volume_noise),
        .o_active_mask      (o_active_mask),
        .o_duty_pulse_one   (o_duty_pulse_one),
        .o_duty_pulse_two   (o_duty_pulse_two)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void clear_channels();
        for (int c = 0; c < OUT_CHANNELS; c++) begin
            ch_len_duty[c] = '0;
            ch_envelope[c] = '0;
            ch_control[c]  = '0;
            ch_volume[c]   = '0;
            ch_active[c]   = 1'b0;
        end
    endfunction

    function automatic t_status apply_channel_item(logic cmd, logic [CH_SEL_W-1:0] ch,
                                                   logic [REG_SEL_W-1:0] rsel,
                                                   logic [DATA_W-1:0] data,
                                                   logic [TIMER_W-1:0] tmr);
        t_status st;
        if (cmd == CMD_WRITE) begin
            if (ch != CH_UNUSED) begin
                case (rsel)
                    REG_LEN_DUTY: ch_len_duty[ch] = data;
                    REG_ENVELOPE: ch_envelope[ch] = data;
                    REG_CONTROL:  ch_control[ch]  = data[7:6];
                    default: ;
                endcase
            end
        end else begin
            for (int c = 0; c < OUT_CHANNELS; c++) begin
                if (ch_control[c][1]) begin
                    ch_active[c]     = 1'b1;
                    ch_control[c][1] = 1'b0;
                    ch_volume[c]     = ch_envelope[c][7:4];
                    if (ch_len_duty[c][LEN_W-1:0] == '0)
                        ch_len_duty[c][LEN_W-1:0] = LEN_RELOAD;
                end
                if (ch_control[c][0] && tmr[LEN_TICK_BITS-1:0] == '0) begin
                    if (ch_len_duty[c][LEN_W-1:0] != '0) begin
                        ch_len_duty[c][LEN_W-1:0] = ch_len_duty[c][LEN_W-1:0] - LEN_W'(1);
                    end else begin
                        ch_volume[c] = '0;
                        ch_active[c] = 1'b0;
                    end
                end
                if (tmr == '0 && ch_envelope[c][ENV_PERIOD_W-1:0] != '0) begin
                    if (ch_envelope[c][3]) begin
                        if (ch_volume[c] != VOL_MAX)
                            ch_volume[c] = ch_volume[c] + VOL_W'(1);
                    end else if (ch_volume[c] != '0) begin
                        ch_volume[c] = ch_volume[c] - VOL_W'(1);
                    end
                end
            end
        end
        st.vol_one   = ch_volume[0];
        st.vol_two   = ch_volume[1];
        st.vol_noise = ch_volume[2];
        st.active    = {ch_active[2], ch_active[1], ch_active[0]};
        st.duty_one  = ch_len_duty[0][7:6];
        st.duty_two  = ch_len_duty[1][7:6];
        return st;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_status want;
        if (!i_rst_n) begin
            clear_channels();
            status_expected_q.delete();
            stall_count = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (status_expected_q.size() == 0) begin
                    $display("%0t: status item with none expected, actual %h", $time,
                             {o_volume_pulse_one, o_volume_pulse_two, o_volume_noise,
                              o_active_mask, o_duty_pulse_one, o_duty_pulse_two});
                    error_count++;
                end else begin
                    want = status_expected_q.pop_front();
                    compare_field("volume_pulse_one", want.vol_one, o_volume_pulse_one);
                    compare_field("volume_pulse_two", want.vol_two, o_volume_pulse_two);
                    compare_field("volume_noise", want.vol_noise, o_volume_noise);
                    compare_field("active_mask", want.active, o_active_mask);
                    compare_field("duty_pulse_one", want.duty_one, o_duty_pulse_one);
                    compare_field("duty_pulse_two", want.duty_two, o_duty_pulse_two);
                    checked_count++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (i_command == CMD_TICK) begin
                    tick_count++;
                end else begin
                    write_count++;
                    if (i_channel_sel == CH_UNUSED || i_reg_sel == REG_UNUSED)
                        ignored_writes++;
                end
                status_expected_q.push_back(apply_channel_item(i_command, i_channel_sel,
                                            i_reg_sel, i_write_data, i_timer));
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_count = 0;
            else
                stall_count++;
        end
    end

    initial begin : watchdog
        while (stall_count < STALL_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles without progress", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    always @(negedge i_clk) begin : receiver
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_SPAN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else if (receiver_quiet) begin
            i_out_ready = 1'b1;
        end else begin
            i_out_ready = ($urandom_range(99) >= 26);
        end
    end

    task automatic send_item(input logic cmd, input logic [CH_SEL_W-1:0] ch,
                             input logic [REG_SEL_W-1:0] rsel,
                             input logic [DATA_W-1:0] data,
                             input logic [TIMER_W-1:0] tmr);
        @(negedge i_clk);
        if (!sender_quiet) begin
            while ($urandom_range(99) < 26) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid    = 1'b1;
        i_command     = cmd;
        i_channel_sel = ch;
        i_reg_sel     = rsel;
        i_write_data  = data;
        i_timer       = tmr;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_random_item();
        logic                 cmd;
        logic [CH_SEL_W-1:0]  ch;
        logic [REG_SEL_W-1:0] rsel;
        logic [TIMER_W-1:0]   tmr;
        cmd  = ($urandom_range(99) < 50) ? CMD_TICK : CMD_WRITE;
        ch   = ($urandom_range(15) == 0) ? CH_UNUSED : CH_SEL_W'($urandom_range(2));
        rsel = ($urandom_range(15) == 0) ? REG_UNUSED : REG_SEL_W'($urandom_range(2));
        case ($urandom_range(3))
            0: tmr = '0;
            1: tmr = {2'($urandom_range(3)), 14'd0};
            default: tmr = TIMER_W'($urandom);
        endcase
        send_item(cmd, ch, rsel, DATA_W'($urandom), tmr);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (status_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_register_writes();
        send_item(CMD_WRITE, CH_PULSE_ONE, REG_LEN_DUTY, 8'hFF, 16'hFFFF);
        send_item(CMD_WRITE, CH_PULSE_TWO, REG_LEN_DUTY, 8'h40, 16'h0000);
        send_item(CMD_WRITE, CH_NOISE, REG_LEN_DUTY, 8'h00, 16'h0000);
        send_item(CMD_WRITE, CH_UNUSED, REG_LEN_DUTY, 8'hAA, 16'h0000);
        send_item(CMD_WRITE, CH_PULSE_ONE, REG_UNUSED, 8'h55, 16'h0000);
        send_item(CMD_WRITE, CH_PULSE_ONE, REG_ENVELOPE, 8'hF7, 16'h0000);
        send_item(CMD_WRITE, CH_PULSE_TWO, REG_ENVELOPE, 8'h09, 16'h0000);
        send_item(CMD_WRITE, CH_NOISE, REG_ENVELOPE, 8'h80, 16'h0000);
    endtask

    task automatic test_length_counter();
        send_item(CMD_WRITE, CH_PULSE_ONE, REG_CONTROL, 8'hC0, 16'h0000);
        send_item(CMD_WRITE, CH_PULSE_TWO, REG_CONTROL, 8'h80, 16'h0000);
        send_item(CMD_WRITE, CH_NOISE, REG_CONTROL, 8'hFF, 16'h0000);
        send_item(CMD_TICK, CH_PULSE_ONE, REG_LEN_DUTY, 8'h00, 16'hFFFF);
        send_item(CMD_TICK, CH_PULSE_ONE, REG_LEN_DUTY, 8'h00, 16'h0000);
        send_item(CMD_TICK, CH_PULSE_ONE, REG_LEN_DUTY, 8'h00, 16'h4000);
        send_item(CMD_WRITE, CH_NOISE, REG_LEN_DUTY, 8'h01, 16'h0000);
        send_item(CMD_TICK, CH_PULSE_ONE, REG_LEN_DUTY, 8'h00, 16'h8000);
        send_item(CMD_TICK, CH_PULSE_ONE, REG_LEN_DUTY, 8'h00, 16'hC000);
    endtask

    task automatic test_envelope();
        send_item(CMD_WRITE, CH_NOISE, REG_ENVELOPE, 8'h0F, 16'h0000);
        send_item(CMD_TICK, CH_PULSE_ONE, REG_LEN_DUTY, 8'h00, 16'h0000);
        send_item(CMD_WRITE, CH_PULSE_TWO, REG_ENVELOPE, 8'hF9, 16'h0000);
        send_item(CMD_WRITE, CH_PULSE_TWO, REG_CONTROL, 8'h80, 16'h0000);
        send_item(CMD_TICK, CH_PULSE_ONE, REG_LEN_DUTY, 8'h00, 16'h0000);
        send_item(CMD_WRITE, CH_PULSE_ONE, REG_ENVELOPE, 8'h01, 16'h0000);
        send_item(CMD_WRITE, CH_PULSE_ONE, REG_CONTROL, 8'h80, 16'h0000);
        send_item(CMD_TICK, CH_PULSE_ONE, REG_LEN_DUTY, 8'h00, 16'h0000);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_item();
    endtask

    task automatic test_back_to_back(input int count);
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b1;
        repeat (count) send_random_item();
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    task automatic test_receiver_hold_off();
        sender_quiet = 1'b1;
        hold_off_req = 1'b1;
        repeat (30) send_random_item();
        sender_quiet = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (100) send_random_item();
        wait_for_results();
        repeat (100) send_random_item();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_WRITE;
        i_channel_sel = CH_PULSE_ONE;
        i_reg_sel     = REG_LEN_DUTY;
        i_write_data  = '0;
        i_timer       = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_writes();
        test_length_counter();
        test_envelope();
        test_random_traffic(900);
        test_back_to_back(560);
        test_receiver_hold_off();
        test_sender_pause();
        wait_for_results();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d register writes (%0d to unused slots) and %0d timer ticks.",
                 write_count, ignored_writes, tick_count);
        $display("Checked %0d status items, %0d field mismatches.", checked_count, error_count);
        if (error_count == 0 && status_expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
